/* src/bdhr_pkg.sv */
`timescale 1ns / 1ps

package bdhr_pkg;

  // Register file geometry
  localparam int REG_W   = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int INDEX_W = 2;

  localparam logic [INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [INDEX_W-1:0] REG_HOLD     = 2'd1;
  localparam logic [INDEX_W-1:0] REG_REPEAT   = 2'd2;

  localparam logic [REG_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [REG_W-1:0] HOLD_RST     = 16'd500;
  localparam logic [REG_W-1:0] REPEAT_RST   = 16'd150;

  // Event kinds
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HOLD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  typedef struct packed {
    logic [REG_W-1:0] debounce_time;
    logic [REG_W-1:0] hold_time;
    logic [REG_W-1:0] repeat_interval;
  } cfg_t;

endpackage

/* src/bdhr_in_if.sv */
`timescale 1ns / 1ps

// Sample channel: one button sample per word
interface bdhr_in_if #(
  parameter int BUTTON_BITS = 4,
  parameter int TIME_BITS   = 32
);
  logic                   valid;
  logic                   ready;
  logic                   read_ok;
  logic [BUTTON_BITS-1:0] button_code;
  logic [TIME_BITS-1:0]   sample_time;

  modport source (output valid, read_ok, button_code, sample_time, input ready);
  modport sink   (input valid, read_ok, button_code, sample_time, output ready);
endinterface

/* src/bdhr_out_if.sv */
`timescale 1ns / 1ps

// Event channel: one button event per word
interface bdhr_out_if #(
  parameter int BUTTON_BITS = 4
);
  logic                        valid;
  logic                        ready;
  logic [BUTTON_BITS-1:0]      event_button;
  logic [bdhr_pkg::KIND_W-1:0] event_kind;

  modport source (output valid, event_button, event_kind, input ready);
  modport sink   (input valid, event_button, event_kind, output ready);
endinterface

/* src/bdhr_cfg.sv */
`timescale 1ns / 1ps

module bdhr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdhr_pkg::ADDR_W-1:0]   paddr,
  input  logic [bdhr_pkg::DATA_W-1:0]   pwdata,
  output logic [bdhr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output bdhr_pkg::cfg_t                cfg
);

  bdhr_pkg::cfg_t                   cfg_r;
  bdhr_pkg::cfg_t                   cfg_nxt;
  logic [bdhr_pkg::INDEX_W-1:0]     idx;
  logic                             wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[bdhr_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  // Register write decode; index 3 is unmapped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        bdhr_pkg::REG_DEBOUNCE: cfg_nxt.debounce_time   = pwdata[bdhr_pkg::REG_W-1:0];
        bdhr_pkg::REG_HOLD:     cfg_nxt.hold_time       = pwdata[bdhr_pkg::REG_W-1:0];
        bdhr_pkg::REG_REPEAT:   cfg_nxt.repeat_interval = pwdata[bdhr_pkg::REG_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= bdhr_pkg::DEBOUNCE_RST;
      cfg_r.hold_time       <= bdhr_pkg::HOLD_RST;
      cfg_r.repeat_interval <= bdhr_pkg::REPEAT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      bdhr_pkg::REG_DEBOUNCE: prdata = bdhr_pkg::DATA_W'(cfg_r.debounce_time);
      bdhr_pkg::REG_HOLD:     prdata = bdhr_pkg::DATA_W'(cfg_r.hold_time);
      bdhr_pkg::REG_REPEAT:   prdata = bdhr_pkg::DATA_W'(cfg_r.repeat_interval);
      default:                prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* src/bdhr_core.sv */
`timescale 1ns / 1ps

module bdhr_core #(
  parameter int BUTTON_BITS = 4,
  parameter int TIME_BITS   = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bdhr_in_if.sink                     in_s,
  input  bdhr_pkg::cfg_t              cfg,
  input  logic                        space,
  output logic                        evt_valid,
  output logic [BUTTON_BITS-1:0]      evt_button,
  output logic [bdhr_pkg::KIND_W-1:0] evt_kind
);

  // Input register
  logic                   v_r;
  logic                   ok_r;
  logic [BUTTON_BITS-1:0] raw_r;
  logic [TIME_BITS-1:0]   now_r;

  // Debounce state
  logic [BUTTON_BITS-1:0] prev_r, prev_nxt;
  logic [BUTTON_BITS-1:0] stable_r, stable_nxt;
  logic [TIME_BITS-1:0]   chg_r, chg_nxt;
  logic [TIME_BITS-1:0]   press_r, press_nxt;
  logic [TIME_BITS-1:0]   rep_r, rep_nxt;

  logic                   go;
  logic                   in_ready;
  logic [TIME_BITS-1:0]   since_chg, since_press, since_rep;
  logic                   ev;
  logic [BUTTON_BITS-1:0] ev_btn;
  logic [bdhr_pkg::KIND_W-1:0] ev_kind;

  assign go        = v_r && space;
  assign in_ready  = !v_r || go;
  assign in_s.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_s.valid) begin
      ok_r  <= in_s.read_ok;
      raw_r <= in_s.button_code;
      now_r <= in_s.sample_time;
    end
  end

  // Elapsed times wrap with the timestamp width
  assign since_chg   = now_r - chg_nxt;
  assign since_press = now_r - press_r;
  assign since_rep   = now_r - rep_r;

  // Event decision for the sample in the input register
  always_comb begin
    prev_nxt   = prev_r;
    stable_nxt = stable_r;
    chg_nxt    = chg_r;
    press_nxt  = press_r;
    rep_nxt    = rep_r;
    ev         = 1'b0;
    ev_btn     = stable_r;
    ev_kind    = bdhr_pkg::KIND_PRESS;
    if (!ok_r) begin
      // failed read releases a stable button
      if (stable_r != '0) begin
        ev         = 1'b1;
        ev_kind    = bdhr_pkg::KIND_RELEASE;
        stable_nxt = '0;
        prev_nxt   = '0;
      end
    end else begin
      if (raw_r != prev_r) begin
        prev_nxt = raw_r;
        chg_nxt  = now_r;
      end
      if (since_chg > TIME_BITS'(cfg.debounce_time) && stable_r != raw_r) begin
        ev         = 1'b1;
        ev_btn     = raw_r;
        ev_kind    = bdhr_pkg::KIND_PRESS;
        stable_nxt = raw_r;
        press_nxt  = now_r;
        rep_nxt    = now_r;
      end else if (stable_r != '0 &&
                   since_press > TIME_BITS'(cfg.hold_time) &&
                   since_rep > TIME_BITS'(cfg.repeat_interval)) begin
        ev      = 1'b1;
        ev_kind = bdhr_pkg::KIND_HOLD;
        rep_nxt = now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      stable_r <= '0;
      chg_r    <= '0;
      press_r  <= '0;
      rep_r    <= '0;
    end else if (go) begin
      prev_r   <= prev_nxt;
      stable_r <= stable_nxt;
      chg_r    <= chg_nxt;
      press_r  <= press_nxt;
      rep_r    <= rep_nxt;
    end
  end

  assign evt_valid  = go && ev;
  assign evt_button = ev_btn;
  assign evt_kind   = ev_kind;

  // A press makes its button the stable one
  a_press_sets_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (evt_valid && evt_kind == bdhr_pkg::KIND_PRESS) |=> stable_r == $past(raw_r))
    else $error("press did not latch stable button");

  // Release and hold always name a real button
  a_nonzero_btn: assert property (@(posedge clk) disable iff (!rst_n)
    (evt_valid && (evt_kind == bdhr_pkg::KIND_RELEASE || evt_kind == bdhr_pkg::KIND_HOLD))
    |-> evt_button != '0)
    else $error("release or hold with no button");

  // Release clears the stable and previous button codes
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (evt_valid && evt_kind == bdhr_pkg::KIND_RELEASE) |=> (stable_r == '0 && prev_r == '0))
    else $error("release left state behind");

  // Stall only while a sample is held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v_r && !space))
    else $error("input stalled without a held sample");

endmodule

/* src/bdhr_out_buf.sv */
`timescale 1ns / 1ps

// Two-word output buffer: head register plus skid entry
module bdhr_out_buf #(
  parameter int WIDTH = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [1:0]       cnt_r, cnt_nxt;
  logic [WIDTH-1:0] head_r, head_nxt;
  logic [WIDTH-1:0] skid_r, skid_nxt;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign space     = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    if (pop) begin
      head_nxt = skid_r;
      cnt_nxt  = cnt_r - 2'd1;
    end
    if (push) begin
      if (cnt_nxt == 2'd0) begin
        head_nxt = push_data;
      end else begin
        skid_nxt = push_data;
      end
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  // Never pushed while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2)
    else $error("push into full output buffer");

  // Count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("output buffer count slip");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

endmodule

/* src/button_debounce_hold_repeat.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Word
// in_s      in   valid/ready    read_ok, button_code, sample_time
// out_s     out  valid/ready    event_button, event_kind (0 press, 1 hold, 2 release)
// cfg (APB) in   psel/penable   debounce_time @0x0, hold_time @0x4, repeat_interval @0x8
//
// One sample per cycle sustained while the output buffer has space; a sample is held in the input
// register and its event, if any, reaches out_s from the output buffer's head register.
// Synchronous active-low reset: timers, codes and stamps to zero, registers to 30/500/150.
// A two-word output buffer lets samples keep flowing while an event waits;
// input stalls only when that buffer is full and the held sample cannot retire.
module button_debounce_hold_repeat #(
  parameter int BUTTON_BITS = 4,
  parameter int TIME_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bdhr_in_if.sink                       in_s,
  bdhr_out_if.source                    out_s,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdhr_pkg::ADDR_W-1:0]   paddr,
  input  logic [bdhr_pkg::DATA_W-1:0]   pwdata,
  output logic [bdhr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int EVT_W = BUTTON_BITS + bdhr_pkg::KIND_W;

  bdhr_pkg::cfg_t              cfg;
  logic                        space;
  logic                        evt_valid;
  logic [BUTTON_BITS-1:0]      evt_button;
  logic [bdhr_pkg::KIND_W-1:0] evt_kind;
  logic [EVT_W-1:0]            buf_data;

  bdhr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdhr_core #(
    .BUTTON_BITS (BUTTON_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_s),
    .cfg        (cfg),
    .space      (space),
    .evt_valid  (evt_valid),
    .evt_button (evt_button),
    .evt_kind   (evt_kind)
  );

  bdhr_out_buf #(
    .WIDTH (EVT_W)
  ) u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (evt_valid),
    .push_data ({evt_button, evt_kind}),
    .space     (space),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .out_data  (buf_data)
  );

  assign out_s.event_button = buf_data[EVT_W-1:bdhr_pkg::KIND_W];
  assign out_s.event_kind   = buf_data[bdhr_pkg::KIND_W-1:0];

endmodule
